@@ design/mbiod_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbiod_pkg : shared types and constants for the main bus I/O decoder
// Item layouts, address map, register indexes and colour expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package mbiod_pkg;

   // Palette geometry
   localparam int PAL_WORDS = 768;
   localparam int PAL_IDX_W = $clog2(PAL_WORDS);

   // Address map, compared on address bits 23:3 (eight-byte windows)
   localparam logic [20:0] PORT_BLOCK = 21'(24'h180000 >> 3);
   localparam logic [20:0] VID_BLOCK  = 21'(24'h0C0000 >> 3);
   localparam logic [20:0] SND_BLOCK  = 21'(24'h140000 >> 3);
   localparam logic [3:0]  PAL_MEG    = 4'(24'h100000 >> 20);
   // Sound register word that raises the NMI (byte offset 2 and 3)
   localparam logic [1:0]  SND_NMI_WORD = 2'(24'h140002 >> 1);

   // Scroll offsets
   localparam logic [16:0] XF_OFFSET = 17'd3;
   localparam logic [16:0] XB_OFFSET = 17'd7;
   localparam logic [16:0] Y_OFFSET  = 17'd12;

   // Access codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [7:0] CSR_DIP_A = 8'd0;
   localparam logic [7:0] CSR_DIP_B = 8'd1;
   localparam logic [7:0] CSR_DIP_C = 8'd2;
   localparam logic [7:0] CSR_DIP_D = 8'd3;

   // DIP reset values
   localparam logic [7:0] DIP_A_RST = 8'hFF;
   localparam logic [7:0] DIP_B_RST = 8'hE1;
   localparam logic [7:0] DIP_C_RST = 8'hDA;
   localparam logic [7:0] DIP_D_RST = 8'hFF;

   typedef struct packed {
      logic        op;
      logic        word_access;
      logic [23:0] bus_address;
      logic [15:0] write_data;
      logic [15:0] player1_inputs;
      logic [15:0] player2_inputs;
   } req_type;

   typedef struct packed {
      logic [15:0]          read_data;
      logic                 palette_valid;
      logic [PAL_IDX_W-1:0] palette_index;
      logic [23:0]          palette_rgb;
      logic [16:0]          scroll_x_front;
      logic [16:0]          scroll_y_front;
      logic [16:0]          scroll_x_back;
      logic [16:0]          scroll_y_back;
      logic                 nmi_pulse;
      logic [7:0]           sound_latch;
   } rsp_type;

   // 5-bit colour channel to 8 bits, top bits repeated below
   function automatic logic [7:0] expand5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

endpackage

`default_nettype wire

@@ design/arcade_main_bus_io_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_main_bus_io_decoder : main CPU bus I/O decoder
// Input port reads, palette writes with colour expansion, video scroll
// registers and sound CPU command registers.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    mbiod_pkg::req_type
//  rsp      out        rsp_valid/stall    mbiod_pkg::rsp_type
//  csr      in         csr_valid/ready    8-bit index, 8-bit data
//
//  Result register loaded from the input stage register: the palette read
//  and the input register load share the accepting edge, then the item is
//  decoded into the result register when the result side is free.
//  One item per cycle is sustained while rsp is not stalled; back-to-back
//  palette writes to the same entry are forwarded around the memory.
//  After reset a clearing pass zeroes all 768 palette entries, one entry a
//  cycle; req_stall is held high meanwhile (csr writes still taken).
//  A stalled result holds the input stage, which then stalls req.
// ----------------------------------------------------------------------------
`default_nettype none

module arcade_main_bus_io_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mbiod_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mbiod_pkg::rsp_type     rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);
   import mbiod_pkg::*;

   // Control
   logic                 clearing_ff;
   logic [PAL_IDX_W-1:0] clr_cnt_ff;
   logic                 s1_valid_ff;
   logic                 rsp_valid_ff;
   logic                 req_accept;
   logic                 s1_go;

   // Items
   req_type s1_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Configuration
   logic [7:0] dip_a_ff, dip_b_ff, dip_c_ff, dip_d_ff;

   // Register state
   logic [7:0]  vid_ff [8];
   logic [7:0]  vid_in [8];
   logic [7:0]  snd_ff [8];
   logic [7:0]  snd_in [8];
   logic [16:0] scroll_ff [4];
   logic [16:0] scroll_in [4];

   // Palette memory and its ports
   logic [15:0]          pal_mem [PAL_WORDS];
   logic [15:0]          pal_rd_ff;
   logic                 pal_hit_ff;
   logic [15:0]          pal_fwd_ff;
   logic                 pal_we;
   logic [PAL_IDX_W-1:0] pal_waddr;
   logic [15:0]          pal_wdata;
   logic [PAL_IDX_W-1:0] req_idx;

   // Input stage decode
   logic                 s1_pal;
   logic [PAL_IDX_W-1:0] s1_idx;
   logic [15:0]          s1_old;
   logic [15:0]          s1_new;
   logic [2:0]           s1_n;
   logic [15:0]          port_val;

   // Handshakes
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clearing_ff || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign req_idx    = req_data.bus_address[PAL_IDX_W:1];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= DIP_A_RST;
         dip_b_ff <= DIP_B_RST;
         dip_c_ff <= DIP_C_RST;
         dip_d_ff <= DIP_D_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_DIP_A) dip_a_ff <= csr_wdata;
         if (csr_index == CSR_DIP_B) dip_b_ff <= csr_wdata;
         if (csr_index == CSR_DIP_C) dip_c_ff <= csr_wdata;
         if (csr_index == CSR_DIP_D) dip_d_ff <= csr_wdata;
      end
   end

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == PAL_IDX_W'(PAL_WORDS - 1)) clearing_ff <= 1'b0;
      end
   end

   // Palette write port: clearing pass or the item leaving the input stage
   always_comb begin
      if (clearing_ff) begin
         pal_we    = 1'b1;
         pal_waddr = clr_cnt_ff;
         pal_wdata = '0;
      end else begin
         pal_we    = s1_go && s1_pal;
         pal_waddr = s1_idx;
         pal_wdata = s1_new;
      end
   end

   // Palette memory, read as the item is taken in
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
      if (req_accept) pal_rd_ff <= pal_mem[req_idx];
   end

   // Forward a write landing on the same entry in the cycle of the read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pal_hit_ff <= pal_we && (pal_waddr == req_idx);
         pal_fwd_ff <= pal_wdata;
      end
   end

   // Input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) s1_ff <= req_data;
   end

   // Palette decode and byte merge
   assign s1_n   = s1_ff.bus_address[2:0];
   assign s1_idx = s1_ff.bus_address[PAL_IDX_W:1];
   assign s1_pal = (s1_ff.op == OP_WRITE)
                && (s1_ff.bus_address[23:20] == PAL_MEG)
                && (s1_ff.bus_address[19:1] < 19'(PAL_WORDS));
   assign s1_old = pal_hit_ff ? pal_fwd_ff : pal_rd_ff;

   always_comb begin
      if (s1_ff.word_access)         s1_new = s1_ff.write_data;
      else if (s1_ff.bus_address[0]) s1_new = {s1_old[15:8], s1_ff.write_data[7:0]};
      else                           s1_new = {s1_ff.write_data[7:0], s1_old[7:0]};
   end

   // Input port value
   always_comb begin
      unique case (s1_n[2:1])
         2'd0:    port_val = {dip_a_ff, 8'hFF} ^ s1_ff.player1_inputs;
         2'd1:    port_val = {dip_b_ff, 8'hFF} ^ s1_ff.player2_inputs;
         2'd2:    port_val = {dip_c_ff, 8'hFF};
         default: port_val = {dip_d_ff, 8'hFF};
      endcase
   end

   // Register updates and result
   always_comb begin
      logic wr;
      logic in_port;
      logic in_vid;
      logic in_snd;
      logic even_word;
      wr        = (s1_ff.op == OP_WRITE);
      in_port   = (s1_ff.bus_address[23:3] == PORT_BLOCK);
      in_vid    = (s1_ff.bus_address[23:3] == VID_BLOCK);
      in_snd    = (s1_ff.bus_address[23:3] == SND_BLOCK);
      even_word = s1_ff.word_access && !s1_n[0];
      vid_in    = vid_ff;
      snd_in    = snd_ff;
      scroll_in = scroll_ff;
      rsp_in    = '0;

      // port reads
      if (!wr && in_port) begin
         if (s1_ff.word_access) rsp_in.read_data = s1_n[0] ? 16'h0000 : port_val;
         else if (s1_n[0])      rsp_in.read_data = {8'h00, port_val[7:0]};
         else                   rsp_in.read_data = {8'h00, port_val[15:8]};
      end

      // palette update
      if (s1_pal) begin
         rsp_in.palette_valid = 1'b1;
         rsp_in.palette_index = s1_idx;
         rsp_in.palette_rgb   = {expand5(s1_new[14:10]), expand5(s1_new[9:5]),
                                 expand5(s1_new[4:0])};
      end

      // video registers; scrolls take the other word, untouched by this write
      if (wr && !s1_pal && in_vid) begin
         if (!s1_ff.word_access) begin
            vid_in[s1_n] = s1_ff.write_data[7:0];
         end else if (even_word) begin
            vid_in[s1_n]         = s1_ff.write_data[7:0];
            vid_in[{s1_n[2:1], 1'b1}] = s1_ff.write_data[15:8];
            unique case (s1_n[2:1])
               2'd0:    scroll_in[2] = {1'b0, vid_ff[5], vid_ff[4]} + XB_OFFSET;
               2'd1:    scroll_in[3] = {1'b0, vid_ff[7], vid_ff[6]} + Y_OFFSET;
               2'd2:    scroll_in[0] = {1'b0, vid_ff[1], vid_ff[0]} + XF_OFFSET;
               default: scroll_in[1] = {1'b0, vid_ff[3], vid_ff[2]} + Y_OFFSET;
            endcase
         end
      end

      // sound registers
      if (wr && !s1_pal && in_snd) begin
         if (!s1_ff.word_access) begin
            snd_in[s1_n]     = s1_ff.write_data[7:0];
            rsp_in.nmi_pulse = (s1_n[2:1] == SND_NMI_WORD);
         end else if (even_word) begin
            snd_in[s1_n]              = s1_ff.write_data[7:0];
            snd_in[{s1_n[2:1], 1'b1}] = s1_ff.write_data[15:8];
            rsp_in.nmi_pulse          = (s1_n[2:1] == SND_NMI_WORD);
         end
      end

      rsp_in.scroll_x_front = scroll_in[0];
      rsp_in.scroll_y_front = scroll_in[1];
      rsp_in.scroll_x_back  = scroll_in[2];
      rsp_in.scroll_y_back  = scroll_in[3];
      rsp_in.sound_latch    = snd_in[2];
   end

   // State registers advance with the item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            vid_ff[i] <= '0;
            snd_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) scroll_ff[i] <= '0;
      end else if (s1_go) begin
         vid_ff    <= vid_in;
         snd_ff    <= snd_in;
         scroll_ff <= scroll_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_go) rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

@@ tb/bus_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_decode_checker : result checker for the main bus I/O decoder
// Watches the request, result and CSR channels. Each accepted request is
// decoded against a private copy of the DIP banks, palette, video and sound
// registers. Each accepted result is compared field by field with the
// oldest decoded access still waiting.
// ----------------------------------------------------------------------------
module bus_decode_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire mbiod_pkg::req_type req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire mbiod_pkg::rsp_type rsp_data,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [7:0]         csr_wdata,
   output int                      results_due,
   output int                      fail_count
);
   import mbiod_pkg::*;

   // Decoder state as seen from the bus
   logic [7:0]  dip_bank [4];
   logic [15:0] palette_mem [PAL_WORDS];
   logic [7:0]  video_bytes [8];
   logic [7:0]  sound_bytes [8];
   logic [16:0] scroll [4];          // x front, y front, x back, y back
   rsp_type     decoded_accesses [$];

   // 5-bit colour channel stretched to 8 bits
   function automatic logic [7:0] widen5(input logic [4:0] c);
      logic [7:0] wide;
      wide = 8'(c);
      return (wide << 3) | (wide >> 2);
   endfunction

   // Apply one bus access to the state and work out its result item
   function automatic rsp_type decode_access(input req_type acc);
      rsp_type     res;
      logic [23:0] addr;
      logic [2:0]  n;
      logic [15:0] port;
      logic [15:0] colour;
      res  = '0;
      addr = acc.bus_address;
      n    = addr[2:0];
      if (acc.op == OP_READ) begin
         // input ports: even byte gives the high half
         if (addr[23:3] == PORT_BLOCK) begin
            case (n[2:1])
               2'd0:    port = {dip_bank[0], 8'hFF} ^ acc.player1_inputs;
               2'd1:    port = {dip_bank[1], 8'hFF} ^ acc.player2_inputs;
               2'd2:    port = {dip_bank[2], 8'hFF};
               default: port = {dip_bank[3], 8'hFF};
            endcase
            if (acc.word_access)
               res.read_data = n[0] ? 16'h0000 : port;
            else
               res.read_data = n[0] ? {8'h00, port[7:0]} : {8'h00, port[15:8]};
         end
      end else if (addr[23:20] == PAL_MEG && addr[19:0] < 20'(2 * PAL_WORDS)) begin
         // palette: byte writes merge, even address is the high byte
         colour = palette_mem[addr[19:1]];
         if (acc.word_access)
            colour = acc.write_data;
         else if (addr[0])
            colour[7:0] = acc.write_data[7:0];
         else
            colour[15:8] = acc.write_data[7:0];
         palette_mem[addr[19:1]] = colour;
         res.palette_valid = 1'b1;
         res.palette_index = addr[PAL_IDX_W:1];
         res.palette_rgb   = {widen5(colour[14:10]), widen5(colour[9:5]),
                              widen5(colour[4:0])};
      end else if (addr[23:3] == VID_BLOCK) begin
         // video registers: even word writes refresh one scroll value
         if (!acc.word_access) begin
            video_bytes[n] = acc.write_data[7:0];
         end else if (!n[0]) begin
            video_bytes[n]        = acc.write_data[7:0];
            video_bytes[n + 3'd1] = acc.write_data[15:8];
            case (n[2:1])
               2'd0:    scroll[2] = {1'b0, video_bytes[5], video_bytes[4]} + 17'd7;
               2'd1:    scroll[3] = {1'b0, video_bytes[7], video_bytes[6]} + 17'd12;
               2'd2:    scroll[0] = {1'b0, video_bytes[1], video_bytes[0]} + 17'd3;
               default: scroll[1] = {1'b0, video_bytes[3], video_bytes[2]} + 17'd12;
            endcase
         end
      end else if (addr[23:3] == SND_BLOCK) begin
         // sound registers: the command word raises the NMI
         if (!acc.word_access) begin
            sound_bytes[n] = acc.write_data[7:0];
            res.nmi_pulse  = (n[2:1] == SND_NMI_WORD);
         end else if (!n[0]) begin
            sound_bytes[n]        = acc.write_data[7:0];
            sound_bytes[n + 3'd1] = acc.write_data[15:8];
            res.nmi_pulse         = (n[2:1] == SND_NMI_WORD);
         end
      end
      res.scroll_x_front = scroll[0];
      res.scroll_y_front = scroll[1];
      res.scroll_x_back  = scroll[2];
      res.scroll_y_back  = scroll[3];
      res.sound_latch    = sound_bytes[2];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count = fail_count + 1;
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.palette_valid !== want.palette_valid)
         report_mismatch("palette_valid", got.palette_valid, want.palette_valid);
      if (got.palette_index !== want.palette_index)
         report_mismatch("palette_index", got.palette_index, want.palette_index);
      if (got.palette_rgb !== want.palette_rgb)
         report_mismatch("palette_rgb", got.palette_rgb, want.palette_rgb);
      if (got.scroll_x_front !== want.scroll_x_front)
         report_mismatch("scroll_x_front", got.scroll_x_front, want.scroll_x_front);
      if (got.scroll_y_front !== want.scroll_y_front)
         report_mismatch("scroll_y_front", got.scroll_y_front, want.scroll_y_front);
      if (got.scroll_x_back !== want.scroll_x_back)
         report_mismatch("scroll_x_back", got.scroll_x_back, want.scroll_x_back);
      if (got.scroll_y_back !== want.scroll_y_back)
         report_mismatch("scroll_y_back", got.scroll_y_back, want.scroll_y_back);
      if (got.nmi_pulse !== want.nmi_pulse)
         report_mismatch("nmi_pulse", got.nmi_pulse, want.nmi_pulse);
      if (got.sound_latch !== want.sound_latch)
         report_mismatch("sound_latch", got.sound_latch, want.sound_latch);
   endtask

   // Channel monitor: results first, since none can belong to this edge's item
   always @(posedge clock) begin
      if (reset) begin
         dip_bank[0] = DIP_A_RST;
         dip_bank[1] = DIP_B_RST;
         dip_bank[2] = DIP_C_RST;
         dip_bank[3] = DIP_D_RST;
         foreach (palette_mem[i]) palette_mem[i] = '0;
         foreach (video_bytes[i]) video_bytes[i] = '0;
         foreach (sound_bytes[i]) sound_bytes[i] = '0;
         foreach (scroll[i]) scroll[i] = '0;
         decoded_accesses.delete();
         fail_count = 0;
         results_due <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_accesses.size() == 0)
               report_mismatch("result item with nothing due", 1, 0);
            else
               compare_result(rsp_data, decoded_accesses.pop_front());
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIP_A: dip_bank[0] = csr_wdata;
               CSR_DIP_B: dip_bank[1] = csr_wdata;
               CSR_DIP_C: dip_bank[2] = csr_wdata;
               CSR_DIP_D: dip_bank[3] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            decoded_accesses.push_back(decode_access(req_data));
         results_due <= decoded_accesses.size();
      end
   end

endmodule

@@ tb/arcade_main_bus_io_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_main_bus_io_decoder_test : testbench top for the main bus I/O decoder
// Drives directed bus accesses at the map edges, then random accesses in
// phases with different DIP settings and idle/stall patterns. Checking is
// left to bus_decode_checker; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module arcade_main_bus_io_decoder_test;
   import mbiod_pkg::*;

   localparam logic [23:0] PORT_ADDR = {PORT_BLOCK, 3'b000};
   localparam logic [23:0] VID_ADDR  = {VID_BLOCK, 3'b000};
   localparam logic [23:0] SND_ADDR  = {SND_BLOCK, 3'b000};
   localparam logic [23:0] PAL_ADDR  = {PAL_MEG, 20'h00000};
   localparam logic [23:0] PAL_END   = PAL_ADDR + 24'(2 * PAL_WORDS);  // first byte past
   localparam int RANDOM_PER_PHASE   = 400;
   localparam int CYCLE_LIMIT        = 400000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index   = '0;
   logic [7:0]  csr_wdata   = '0;

   int          results_due;
   int          fail_count;
   int          cycle_count   = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;

   arcade_main_bus_io_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bus_decode_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .results_due (results_due),
      .fail_count  (fail_count)
   );

   always #10 clock = ~clock;

   // Result side back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one item, with an optional idle gap first; valid stays high after
   task automatic issue_access(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drive_access(input logic op, input logic word, input logic [23:0] addr,
                               input logic [15:0] data, input logic [15:0] p1,
                               input logic [15:0] p2);
      req_type item;
      item.op             = op;
      item.word_access    = word;
      item.bus_address    = addr;
      item.write_data     = data;
      item.player1_inputs = p1;
      item.player2_inputs = p2;
      issue_access(item);
   endtask

   // Drop valid and wait until every result item has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic load_dips(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d);
      logic [7:0] regs [4];
      logic [7:0] vals [4];
      regs = '{CSR_DIP_A, CSR_DIP_B, CSR_DIP_C, CSR_DIP_D};
      vals = '{a, b, c, d};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Random access, weighted towards the mapped windows and their edges
   function automatic req_type random_access();
      req_type item;
      int      kind;
      int      entry;
      item.op             = $urandom_range(1) ? OP_WRITE : OP_READ;
      item.word_access    = 1'($urandom_range(1));
      item.write_data     = 16'($urandom);
      item.player1_inputs = 16'($urandom);
      item.player2_inputs = 16'($urandom);
      kind = $urandom_range(99);
      if (kind < 20) begin
         item.bus_address = PORT_ADDR + 24'($urandom_range(7));
         item.op          = ($urandom_range(99) < 85) ? OP_READ : OP_WRITE;
      end else if (kind < 50) begin
         // a few hot entries so byte merges and back-to-back hits are common
         entry = ($urandom_range(99) < 40) ? $urandom_range(3) : $urandom_range(PAL_WORDS - 1);
         if ($urandom_range(99) < 10)
            entry = PAL_WORDS - 1;
         item.bus_address = PAL_ADDR + 24'(2 * entry) + 24'($urandom_range(1));
         item.op          = ($urandom_range(99) < 90) ? OP_WRITE : OP_READ;
      end else if (kind < 65) begin
         item.bus_address = VID_ADDR + 24'($urandom_range(7));
         item.op          = ($urandom_range(99) < 85) ? OP_WRITE : OP_READ;
      end else if (kind < 80) begin
         item.bus_address = SND_ADDR + 24'($urandom_range(7));
         item.op          = ($urandom_range(99) < 85) ? OP_WRITE : OP_READ;
      end else if (kind < 90) begin
         case ($urandom_range(9))
            0:       item.bus_address = PORT_ADDR - 24'd1;
            1:       item.bus_address = PORT_ADDR + 24'd8;
            2:       item.bus_address = PAL_ADDR - 24'd1;
            3:       item.bus_address = PAL_END;
            4:       item.bus_address = VID_ADDR - 24'd1;
            5:       item.bus_address = VID_ADDR + 24'd8;
            6:       item.bus_address = SND_ADDR - 24'd1;
            7:       item.bus_address = SND_ADDR + 24'd8;
            8:       item.bus_address = 24'h000000;
            default: item.bus_address = 24'hFFFFFF;
         endcase
      end else begin
         item.bus_address = 24'($urandom);
      end
      return item;
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: port reads, and reads outside the port window, under reset DIP values
      drive_access(OP_READ, 1'b0, PORT_ADDR,          16'h0000, 16'h0000, 16'h0000);
      drive_access(OP_READ, 1'b0, PORT_ADDR + 24'd1,  16'h0000, 16'hFFFF, 16'h0000);
      drive_access(OP_READ, 1'b1, PORT_ADDR + 24'd2,  16'h0000, 16'h0000, 16'hFFFF);
      drive_access(OP_READ, 1'b1, PORT_ADDR + 24'd3,  16'h0000, 16'hFFFF, 16'hFFFF);
      drive_access(OP_READ, 1'b0, PORT_ADDR + 24'd4,  16'h0000, 16'hFFFF, 16'hFFFF);
      drive_access(OP_READ, 1'b1, PORT_ADDR + 24'd6,  16'h0000, 16'h0000, 16'h0000);
      drive_access(OP_READ, 1'b0, PORT_ADDR + 24'd7,  16'h0000, 16'h0000, 16'h0000);
      drive_access(OP_READ, 1'b1, PORT_ADDR + 24'd8,  16'h0000, 16'hFFFF, 16'hFFFF);
      drive_access(OP_READ, 1'b1, 24'h000000,         16'h0000, 16'hFFFF, 16'hFFFF);
      drive_access(OP_READ, 1'b1, PAL_ADDR,           16'h0000, 16'h1234, 16'h5678);
      // palette: full word, byte merges, last entry by odd word, just past
      drive_access(OP_WRITE, 1'b1, PAL_ADDR,          16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b0, PAL_ADDR,          16'hFF00, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b0, PAL_ADDR + 24'd1,  16'h005A, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, PAL_END - 24'd1,   16'h7FFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b0, PAL_END,           16'hFFFF, 16'h0000, 16'h0000);
      // video: all four register words written with all ones, byte and odd word writes
      drive_access(OP_WRITE, 1'b1, VID_ADDR,          16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, VID_ADDR + 24'd2,  16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, VID_ADDR + 24'd4,  16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, VID_ADDR + 24'd6,  16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b0, VID_ADDR + 24'd1,  16'h0012, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, VID_ADDR + 24'd3,  16'h0000, 16'h0000, 16'h0000);
      // sound: NMI by either byte and by word, odd word ignored, latch updates
      drive_access(OP_WRITE, 1'b0, SND_ADDR + 24'd2,  16'h00A5, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b0, SND_ADDR + 24'd3,  16'h003C, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, SND_ADDR + 24'd2,  16'hBEEF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, SND_ADDR + 24'd3,  16'h1111, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, SND_ADDR,          16'hFFFF, 16'h0000, 16'h0000);
      drive_access(OP_WRITE, 1'b1, 24'hFFFFFF,        16'hFFFF, 16'h0000, 16'h0000);

      // Random phases, each reloading the DIP setting and setting its idle and stall pattern
      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: load_dips(8'h00, 8'h00, 8'h00, 8'h00);
            1: load_dips(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            3: load_dips(8'h55, 8'hAA, 8'h0F, 8'hF0);
            default: load_dips(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         case (phase)
            1:       begin send_idle_pct = 53; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 53; end
            3, 4:    begin send_idle_pct = 15; stall_pct = 15; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
         endcase
         repeat (RANDOM_PER_PHASE) issue_access(random_access());
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
